[hdl/ghd_pkg.sv]
package ghd_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 1024;
    localparam int NodeW = 6;
    localparam int EdgeW = 10;
    localparam int EdgeCntW = 11;
    localparam int EdgeMemW = 2 * NodeW + 32;

    typedef enum logic [1:0] {
        FUNC_LOAD_NODE = 2'd0,
        FUNC_LOAD_EDGE = 2'd1,
        FUNC_CLEAR     = 2'd2,
        FUNC_RUN       = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_STEP_COUNT = 2'd1,
        CFG_TIME_STEP  = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EDGE_WR,
        ST_STEP_BEGIN,
        ST_CLR_LAP,
        ST_E_RD,
        ST_E_ND,
        ST_E_NS,
        ST_E_MUL_D,
        ST_E_MUL_S,
        ST_E_TERM,
        ST_E_ACC,
        ST_U_RD,
        ST_U_MUL,
        ST_U_WR,
        ST_OUT_RD,
        ST_OUT_EMIT
    } state_t;

    typedef struct packed {
        logic store_node;
        logic div_start;
        logic edge_rd;
        logic edge_wr_new;
        logic edge_wr_hit;
        logic edge_clear;
        logic lap_clear;
        logic rd_dst;
        logic rd_src;
        logic mul_d;
        logic mul_s;
        logic term;
        logic acc;
        logic upd_rd;
        logic upd_mul;
        logic upd_wr;
        logic out_rd;
        logic emit;
        logic [NodeW-1:0] idx;
        logic [EdgeW-1:0] eidx;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic edge_match;
        logic edge_valid;
        logic [EdgeCntW-1:0] edge_total;
    } stat_t;

endpackage

[hdl/ghd_ram.sv]
module ghd_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/ghd_datapath.sv]
module ghd_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ghd_pkg::cmd_t                cmd,
    output ghd_pkg::stat_t               stat,
    input  logic [5:0]                   node_index,
    input  logic [5:0]                   neighbor_index,
    input  logic [31:0]                  edge_weight,
    input  logic signed [31:0]           heat_value,
    input  logic [31:0]                  multiplicity,
    input  logic [16:0]                  time_step,
    input  logic [6:0]                   n_used,
    output logic [5:0]                   out_node,
    output logic signed [31:0]           out_heat,
    output logic                         last_node,
    output logic                         result_valid
);

    localparam int NW = ghd_pkg::NodeW;

    logic [NW-1:0] node_raddr;
    logic [NW-1:0] node_waddr;
    logic          heat_we;
    logic [31:0]   heat_wdata;
    logic [31:0]   heat_rdata;
    logic [31:0]   mult_rdata;
    logic          edge_we;
    logic [ghd_pkg::EdgeW-1:0] edge_waddr;
    logic [ghd_pkg::EdgeMemW-1:0] edge_wdata;
    logic [ghd_pkg::EdgeMemW-1:0] edge_rdata;

    logic [ghd_pkg::EdgeCntW-1:0] edge_total_reg, edge_total_next;
    logic [NW-1:0]  src_reg, dst_reg;
    logic [NW-1:0]  key_src_reg, key_dst_reg;
    logic [31:0]    cond_reg;
    logic signed [31:0] hd_reg, hs_reg;
    logic [31:0]    md_reg, ms_reg;
    logic signed [31:0] wd_reg;
    logic signed [31:0] diff_reg;
    logic signed [47:0] term_reg;
    logic signed [31:0] upd_reg;
    logic [5:0]     out_node_reg;
    logic signed [31:0] out_heat_reg;
    logic           last_reg, valid_reg;

    logic               lap_we;
    logic [NW-1:0]      lap_waddr;
    logic [NW-1:0]      lap_raddr;
    logic signed [47:0] lap_wdata;
    logic signed [47:0] lap_rdata;
    logic               edge_in_use;

    // divider 2^32 / weight, restoring, one bit per cycle
    logic [33:0] rem_reg;
    logic [32:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [33:0] rem_sh;

    assign rem_sh = {rem_reg[32:0], (dcnt_reg == 6'd32)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= 6'd32;
            rem_reg   <= '0;
            quo_reg   <= '0;
            dvs_reg   <= edge_weight;
        end
        else if (dbusy_reg)
        begin
            if (rem_sh >= {2'b00, dvs_reg})
            begin
                rem_reg <= rem_sh - {2'b00, dvs_reg};
                quo_reg <= {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
            if (dcnt_reg == 6'd0)
            begin
                dbusy_reg <= 1'b0;
            end
            else
            begin
                dcnt_reg <= dcnt_reg - 6'd1;
            end
        end
    end

    // hold the edge endpoints of the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            key_src_reg <= node_index;
            key_dst_reg <= neighbor_index;
        end
    end

    logic [31:0] new_cond;
    always_comb
    begin
        if (dvs_reg == 32'd0)
        begin
            new_cond = '0;
        end
        else if (quo_reg[32])
        begin
            new_cond = '1;
        end
        else
        begin
            new_cond = quo_reg[31:0];
        end
    end

    assign stat.div_done = !dbusy_reg && !cmd.div_start;
    assign stat.edge_total = edge_total_reg;
    assign stat.edge_match = edge_rdata[ghd_pkg::EdgeMemW-1 -: 2*NW]
                             == {key_src_reg, key_dst_reg};
    assign stat.edge_valid = ({1'b0, cmd.eidx} < edge_total_reg);

    always_comb
    begin
        edge_total_next = edge_total_reg;
        if (cmd.edge_clear)
        begin
            edge_total_next = '0;
        end
        else if (cmd.edge_wr_new)
        begin
            edge_total_next = edge_total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
        end
        else
        begin
            edge_total_reg <= edge_total_next;
        end
    end

    assign edge_we    = cmd.edge_wr_new || cmd.edge_wr_hit;
    assign edge_waddr = cmd.edge_wr_new ? edge_total_reg[ghd_pkg::EdgeW-1:0] : cmd.eidx;
    assign edge_wdata = {key_src_reg, key_dst_reg, new_cond};

    ghd_ram #(.Width(ghd_pkg::EdgeMemW), .Depth(ghd_pkg::MaxEdges)) u_edge (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (cmd.eidx),
        .rdata (edge_rdata)
    );

    always_comb
    begin
        if (cmd.rd_dst)
        begin
            node_raddr = edge_rdata[ghd_pkg::EdgeMemW-NW-1 -: NW];
        end
        else if (cmd.rd_src)
        begin
            node_raddr = src_reg;
        end
        else
        begin
            node_raddr = cmd.idx;
        end
    end

    assign heat_we    = cmd.store_node || cmd.upd_wr;
    assign node_waddr = cmd.store_node ? node_index : cmd.idx;
    assign heat_wdata = cmd.store_node ? heat_value : upd_reg;

    ghd_ram #(.Width(32), .Depth(ghd_pkg::MaxNodes)) u_heat (
        .clk   (clk),
        .we    (heat_we),
        .waddr (node_waddr),
        .wdata (heat_wdata),
        .raddr (node_raddr),
        .rdata (heat_rdata)
    );

    ghd_ram #(.Width(32), .Depth(ghd_pkg::MaxNodes)) u_mult (
        .clk   (clk),
        .we    (cmd.store_node),
        .waddr (node_index),
        .wdata (multiplicity),
        .raddr (node_raddr),
        .rdata (mult_rdata)
    );

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (x < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    logic signed [65:0] prod;
    logic signed [31:0] mf_heat;
    logic [31:0]        mf_mult;
    logic signed [31:0] ws;
    assign mf_heat = cmd.mul_d ? hd_reg : hs_reg;
    assign mf_mult = cmd.mul_d ? md_reg : ms_reg;
    assign prod = ($signed({34'd0, mf_mult}) * $signed({{34{mf_heat[31]}}, mf_heat})) >>> 16;
    assign ws = sat32(prod);

    logic signed [65:0] tprod;
    assign tprod = ($signed({{34{diff_reg[31]}}, diff_reg})
                   * $signed({34'd0, cond_reg})) >>> 16;

    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat;
    assign acc_sum = {lap_rdata[47], lap_rdata} + {term_reg[47], term_reg};
    always_comb
    begin
        if (acc_sum[48] != acc_sum[47])
        begin
            acc_sat = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[47:0];
        end
    end

    logic [16:0] dt;
    assign dt = time_step[16] ? 17'h10000 : time_step;
    logic signed [65:0] uprod;
    assign uprod = ($signed({{18{lap_rdata[47]}}, lap_rdata})
                   * $signed({49'd0, dt})) >>> 16;

    logic signed [32:0] diff_full;
    assign diff_full = {wd_reg[31], wd_reg} - {ws[31], ws};

    always_ff @(posedge clk)
    begin
        if (cmd.rd_dst)
        begin
            src_reg  <= edge_rdata[ghd_pkg::EdgeMemW-1 -: NW];
            dst_reg  <= edge_rdata[ghd_pkg::EdgeMemW-NW-1 -: NW];
            cond_reg <= edge_rdata[31:0];
        end
        if (cmd.rd_src)
        begin
            hd_reg <= heat_rdata;
            md_reg <= mult_rdata;
        end
        if (cmd.mul_d)
        begin
            hs_reg <= heat_rdata;
            ms_reg <= mult_rdata;
            wd_reg <= ws;
        end
        if (cmd.mul_s)
        begin
            diff_reg <= sat32({{33{diff_full[32]}}, diff_full});
        end
        if (cmd.term)
        begin
            term_reg <= tprod[47:0];
        end
        if (cmd.upd_mul)
        begin
            upd_reg <= sat32({{34{heat_rdata[31]}}, heat_rdata} + uprod);
        end
    end

    // drop edges that touch a node outside the active range
    assign edge_in_use = ({1'b0, src_reg} < n_used) && ({1'b0, dst_reg} < n_used);

    assign lap_we    = cmd.lap_clear || (cmd.acc && edge_in_use);
    assign lap_waddr = cmd.lap_clear ? cmd.idx : src_reg;
    assign lap_wdata = cmd.lap_clear ? 48'sd0 : acc_sat;
    assign lap_raddr = cmd.upd_rd ? cmd.idx : src_reg;

    ghd_ram #(.Width(48), .Depth(ghd_pkg::MaxNodes)) u_lap (
        .clk   (clk),
        .we    (lap_we),
        .waddr (lap_waddr),
        .wdata (lap_wdata),
        .raddr (lap_raddr),
        .rdata (lap_rdata)
    );

    logic [6:0] idx_p1;
    assign idx_p1 = {1'b0, cmd.idx} + 7'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_node_reg <= cmd.idx;
            out_heat_reg <= heat_rdata;
            last_reg     <= (idx_p1 == n_used);
        end
    end

    assign out_node     = out_node_reg;
    assign out_heat     = out_heat_reg;
    assign last_node    = last_reg;
    assign result_valid = valid_reg;

    logic unused_ok;
    assign unused_ok = ^{uprod[65:48], tprod[65:48], cmd.out_rd};

endmodule

[hdl/ghd_ctrl.sv]
module ghd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     func,
    input  logic [6:0]     n_used,
    input  logic [15:0]    step_count,
    input  ghd_pkg::stat_t stat,
    output ghd_pkg::cmd_t  cmd,
    output logic           busy
);

    localparam int NW = ghd_pkg::NodeW;
    localparam int EW = ghd_pkg::EdgeW;

    ghd_pkg::state_t state_reg, state_next;
    logic [NW-1:0]   idx_reg, idx_next;
    logic [EW-1:0]   eidx_reg, eidx_next;
    logic [15:0]     step_reg, step_next;

    logic [6:0] idx_p1;
    logic [ghd_pkg::EdgeCntW-1:0] eidx_p1;
    logic last_idx, last_edge;

    assign idx_p1   = {1'b0, idx_reg} + 7'd1;
    assign eidx_p1  = {1'b0, eidx_reg} + 1'b1;
    assign last_idx = (idx_p1 >= n_used);
    assign last_edge = (eidx_p1 >= stat.edge_total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ghd_pkg::ST_IDLE;
            idx_reg   <= '0;
            eidx_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            eidx_reg  <= eidx_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        eidx_next  = eidx_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.eidx   = eidx_reg;
        busy       = 1'b1;
        case (state_reg)
            ghd_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (ghd_pkg::func_t'(func))
                        ghd_pkg::FUNC_LOAD_NODE:
                        begin
                            cmd.store_node = 1'b1;
                        end
                        ghd_pkg::FUNC_LOAD_EDGE:
                        begin
                            cmd.div_start = 1'b1;
                            state_next = ghd_pkg::ST_DIV;
                        end
                        ghd_pkg::FUNC_CLEAR:
                        begin
                            cmd.edge_clear = 1'b1;
                        end
                        default:
                        begin
                            step_next = step_count;
                            idx_next  = '0;
                            state_next = (step_count == 16'd0) ? ghd_pkg::ST_OUT_RD
                                                               : ghd_pkg::ST_STEP_BEGIN;
                        end
                    endcase
                end
            end
            ghd_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    eidx_next  = '0;
                    cmd.eidx   = '0;
                    if (stat.edge_total == '0)
                    begin
                        state_next = ghd_pkg::ST_EDGE_WR;
                    end
                    else
                    begin
                        state_next = ghd_pkg::ST_SCAN_CMP;
                    end
                end
            end
            ghd_pkg::ST_SCAN_RD:
            begin
                state_next = ghd_pkg::ST_SCAN_CMP;
            end
            ghd_pkg::ST_SCAN_CMP:
            begin
                if (stat.edge_match)
                begin
                    cmd.edge_wr_hit = 1'b1;
                    state_next = ghd_pkg::ST_IDLE;
                end
                else if (last_edge)
                begin
                    state_next = ghd_pkg::ST_EDGE_WR;
                end
                else
                begin
                    eidx_next = eidx_p1[EW-1:0];
                    cmd.eidx  = eidx_p1[EW-1:0];
                    state_next = ghd_pkg::ST_SCAN_RD;
                end
            end
            ghd_pkg::ST_EDGE_WR:
            begin
                if (stat.edge_total[ghd_pkg::EdgeCntW-1] == 1'b0)
                begin
                    cmd.edge_wr_new = 1'b1;
                end
                state_next = ghd_pkg::ST_IDLE;
            end
            ghd_pkg::ST_STEP_BEGIN:
            begin
                idx_next   = '0;
                state_next = ghd_pkg::ST_CLR_LAP;
            end
            ghd_pkg::ST_CLR_LAP:
            begin
                cmd.lap_clear = 1'b1;
                if (last_idx)
                begin
                    idx_next  = '0;
                    eidx_next = '0;
                    cmd.eidx  = '0;
                    state_next = (stat.edge_total == '0) ? ghd_pkg::ST_U_RD
                                                         : ghd_pkg::ST_E_RD;
                end
                else
                begin
                    idx_next = idx_p1[NW-1:0];
                end
            end
            ghd_pkg::ST_E_RD:
            begin
                state_next = ghd_pkg::ST_E_ND;
            end
            ghd_pkg::ST_E_ND:
            begin
                cmd.rd_dst = 1'b1;
                state_next = ghd_pkg::ST_E_NS;
            end
            ghd_pkg::ST_E_NS:
            begin
                cmd.rd_src = 1'b1;
                state_next = ghd_pkg::ST_E_MUL_D;
            end
            ghd_pkg::ST_E_MUL_D:
            begin
                cmd.mul_d  = 1'b1;
                state_next = ghd_pkg::ST_E_MUL_S;
            end
            ghd_pkg::ST_E_MUL_S:
            begin
                cmd.mul_s  = 1'b1;
                state_next = ghd_pkg::ST_E_TERM;
            end
            ghd_pkg::ST_E_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = ghd_pkg::ST_E_ACC;
            end
            ghd_pkg::ST_E_ACC:
            begin
                cmd.acc = 1'b1;
                if (last_edge)
                begin
                    idx_next   = '0;
                    state_next = ghd_pkg::ST_U_RD;
                end
                else
                begin
                    eidx_next  = eidx_p1[EW-1:0];
                    cmd.eidx   = eidx_p1[EW-1:0];
                    state_next = ghd_pkg::ST_E_RD;
                end
            end
            ghd_pkg::ST_U_RD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = ghd_pkg::ST_U_MUL;
            end
            ghd_pkg::ST_U_MUL:
            begin
                cmd.upd_mul = 1'b1;
                state_next  = ghd_pkg::ST_U_WR;
            end
            ghd_pkg::ST_U_WR:
            begin
                cmd.upd_wr = 1'b1;
                if (last_idx)
                begin
                    idx_next = '0;
                    step_next = step_reg - 16'd1;
                    state_next = (step_reg == 16'd1) ? ghd_pkg::ST_OUT_RD
                                                     : ghd_pkg::ST_STEP_BEGIN;
                end
                else
                begin
                    idx_next   = idx_p1[NW-1:0];
                    state_next = ghd_pkg::ST_U_RD;
                end
            end
            ghd_pkg::ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ghd_pkg::ST_OUT_EMIT;
            end
            ghd_pkg::ST_OUT_EMIT:
            begin
                cmd.emit = 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = ghd_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_p1[NW-1:0];
                    state_next = ghd_pkg::ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ghd_pkg::ST_IDLE;
            end
        endcase
    end

    logic unused_ok;
    assign unused_ok = ^{stat.edge_valid};

endmodule

[hdl/graph_heat_diffusion_euler.sv]
// Heat diffusion on a directed weighted graph by explicit Euler steps, signed Q16.16.
// Node and clear items are handled in the idle state; an edge load runs the serial
// 2^32/weight divide, then scans the stored edges for a duplicate of its endpoints.
// A run walks every edge through the single node memory read port in each of the
// step_count Euler steps, then emits one word per node.
// Words appear for one cycle under result_valid and must be taken then.
module graph_heat_diffusion_euler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [5:0]         node_index,
    input  logic [5:0]         neighbor_index,
    input  logic [31:0]        edge_weight,
    input  logic signed [31:0] heat_value,
    input  logic [31:0]        multiplicity,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output logic               result_valid,
    output logic [5:0]         out_node,
    output logic signed [31:0] out_heat,
    output logic               last_node
);

    logic [6:0]  node_count_reg;
    logic [15:0] step_count_reg;
    logic [16:0] time_step_reg;
    logic [6:0]  n_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 7'd1;
            step_count_reg <= 16'd1;
            time_step_reg  <= 17'd6554;
        end
        else if (cfg_we)
        begin
            case (ghd_pkg::cfg_idx_t'(cfg_index))
                ghd_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data[6:0];
                ghd_pkg::CFG_STEP_COUNT: step_count_reg <= cfg_data[15:0];
                ghd_pkg::CFG_TIME_STEP:  time_step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (node_count_reg == 7'd0)
        begin
            n_used = 7'd1;
        end
        else if (node_count_reg > 7'(ghd_pkg::MaxNodes))
        begin
            n_used = 7'(ghd_pkg::MaxNodes);
        end
        else
        begin
            n_used = node_count_reg;
        end
    end

    ghd_pkg::cmd_t  cmd;
    ghd_pkg::stat_t stat;

    ghd_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .func           (func),
        .n_used         (n_used),
        .step_count     (step_count_reg),
        .stat           (stat),
        .cmd            (cmd),
        .busy           (busy)
    );

    ghd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .node_index     (node_index),
        .neighbor_index (neighbor_index),
        .edge_weight    (edge_weight),
        .heat_value     (heat_value),
        .multiplicity   (multiplicity),
        .time_step      (time_step_reg),
        .n_used         (n_used),
        .out_node       (out_node),
        .out_heat       (out_heat),
        .last_node      (last_node),
        .result_valid   (result_valid)
    );

endmodule
